### hw/rtl/epe_pkg.sv
// ----------------------------------------------------------------------------
// epe_pkg - shared definitions for the ellipse point evaluator
// Types, CORDIC constants, arctangent table and angle set-up helpers.
// ----------------------------------------------------------------------------
package epe_pkg;

  // Sine/cosine iteration count and angle resolution
  localparam int CORDIC_STEPS = 16;
  localparam int ANGLE_BITS   = 16;
  localparam int ATAN_DEPTH   = 24;
  localparam int NUM_CELLS    = (CORDIC_STEPS < ATAN_DEPTH) ? CORDIC_STEPS : ATAN_DEPTH;
  localparam int STEP_W       = 5;

  // Angle bits kept after quantisation
  localparam int ANGLE_DROP   = 16 - ((ANGLE_BITS >= 16) ? 16 : ANGLE_BITS);
  localparam logic [15:0] ANGLE_KEEP = 16'(16'hFFFF << ANGLE_DROP);

  // Q30 inverse CORDIC gain for the chosen step count
  localparam logic signed [31:0] CORDIC_GAIN =
    32'(64'd652032874 + (64'd434688583 >> (2 * CORDIC_STEPS)));

  // Register map
  localparam int CFG_ADDR_W = 5;
  typedef enum logic [2:0] {
    REG_SEMI_A   = 3'd0,
    REG_SEMI_B   = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_ROTATION = 3'd4
  } reg_idx_t;

  // One CORDIC lane: Q30 vector and residual turn phase
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } lane_t;

  // Contents of one cell: parameter lane and rotation lane
  typedef struct packed {
    logic       vld;
    logic [1:0] quad_t;
    logic [1:0] quad_r;
    lane_t      lt;
    lane_t      lr;
  } slot_t;

  // Finished result item
  typedef struct packed {
    logic        ovf;
    logic [31:0] py;
    logic [31:0] px;
  } res_t;

  // Arctangent of 2^-i in Q32 turns
  function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051D;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2E;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2F9;
      5'd15:   v = 32'h0000517C;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A2F;
      5'd19:   v = 32'h00000517;
      5'd20:   v = 32'h0000028B;
      5'd21:   v = 32'h00000145;
      5'd22:   v = 32'h000000A2;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // Turn phase of a 16-bit binary angle
  function automatic logic [31:0] angle_phase(input logic [15:0] ang);
    return {ang & ANGLE_KEEP, 16'h0000};
  endfunction

  // Nearest quarter turn
  function automatic logic [1:0] phase_quad(input logic [15:0] ang);
    logic [31:0] sum;
    sum = angle_phase(ang) + 32'h2000_0000;
    return sum[31:30];
  endfunction

  // Starting vector and residual in [-1/8, 1/8) turn
  function automatic lane_t lane_seed(input logic [15:0] ang);
    lane_t l;
    logic [1:0] q;
    q   = phase_quad(ang);
    l.x = CORDIC_GAIN;
    l.y = '0;
    l.z = $signed(angle_phase(ang) - {q, 30'h0});
    return l;
  endfunction

endpackage

### hw/rtl/epe_cordic_cell.sv
// ----------------------------------------------------------------------------
// epe_cordic_cell - one CORDIC micro-rotation step
// Rotates the parameter lane and the rotation lane by +/- atan(2^-step)
// and registers both for the next cell.
// ----------------------------------------------------------------------------
module epe_cordic_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic [epe_pkg::STEP_W-1:0]  step,
  input  epe_pkg::slot_t              slot_i,
  output epe_pkg::slot_t              slot_o
);
  import epe_pkg::*;

  slot_t       slot_r;
  slot_t       slot_nxt;
  logic [31:0] atan_v;

  // One micro-rotation; shifts round towards minus infinity
  function automatic lane_t rotate(input lane_t l, input logic [STEP_W-1:0] s,
                                   input logic [31:0] a);
    lane_t r;
    if (!l.z[31]) begin
      r.x = l.x - (l.y >>> s);
      r.y = l.y + (l.x >>> s);
      r.z = l.z - $signed(a);
    end else begin
      r.x = l.x + (l.y >>> s);
      r.y = l.y - (l.x >>> s);
      r.z = l.z + $signed(a);
    end
    return r;
  endfunction

  assign atan_v = atan_turn(step);

  always_comb begin
    slot_nxt    = slot_i;
    slot_nxt.lt = rotate(slot_i.lt, step, atan_v);
    slot_nxt.lr = rotate(slot_i.lr, step, atan_v);
  end

  // Advance with the rest of the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.vld <= 1'b0;
    end else if (en) begin
      slot_r <= slot_nxt;
    end
  end

  assign slot_o = slot_r;

endmodule

### hw/rtl/epe_transform.sv
// ----------------------------------------------------------------------------
// epe_transform - scale, rotate, translate and saturate
// Unfolds the quadrant, forms a*cos t and b*sin t, rotates by tau, adds the
// centre and clamps to signed 32 bits. Six register stages.
// ----------------------------------------------------------------------------
module epe_transform (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  epe_pkg::slot_t      slot_i,
  input  logic [30:0]         semi_a,
  input  logic [30:0]         semi_b,
  input  logic signed [31:0]  center_x,
  input  logic signed [31:0]  center_y,
  output logic                res_vld,
  output epe_pkg::res_t       res
);
  import epe_pkg::*;

  localparam int P_W   = 33;
  localparam int PR_W  = 65;
  localparam int SUM_W = 66;
  localparam int OFF_W = 35;
  localparam int POS_W = 36;

  typedef struct packed {
    logic signed [31:0] c;
    logic signed [31:0] s;
  } sc_t;

  // Quadrant unfold
  function automatic sc_t quad_map(input lane_t l, input logic [1:0] q);
    sc_t r;
    case (q)
      2'd0:    begin r.c = l.x;  r.s = l.y;  end
      2'd1:    begin r.c = -l.y; r.s = l.x;  end
      2'd2:    begin r.c = -l.x; r.s = -l.y; end
      default: begin r.c = l.y;  r.s = -l.x; end
    endcase
    return r;
  endfunction

  // Clamp to signed 32 bits
  function automatic logic [32:0] clamp32(input logic signed [POS_W-1:0] v);
    logic [32:0] r;
    if (v[POS_W-1:31] == '0 || v[POS_W-1:31] == '1) begin
      r = {1'b0, v[31:0]};
    end else if (v[POS_W-1]) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b1, 32'h7FFF_FFFF};
    end
    return r;
  endfunction

  logic [5:0] vld_r;

  sc_t                      t_sc_a_r, r_sc_a_r;
  logic signed [63:0]       pprod_b_r, qprod_b_r;
  sc_t                      r_sc_b_r, r_sc_c_r;
  logic signed [P_W-1:0]    p_c_r, q_c_r;
  logic signed [PR_W-1:0]   xp1_d_r, xp2_d_r, yp1_d_r, yp2_d_r;
  logic signed [OFF_W-1:0]  offx_e_r, offy_e_r;
  res_t                     res_r;

  logic signed [63:0]       pprod_nxt, qprod_nxt, pround, qround;
  logic signed [SUM_W-1:0]  sx_nxt, sy_nxt;
  logic signed [POS_W-1:0]  posx, posy;
  logic [32:0]              clx, cly;

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], slot_i.vld};
    end
  end

  assign pprod_nxt = $signed({1'b0, semi_a}) * t_sc_a_r.c;
  assign qprod_nxt = $signed({1'b0, semi_b}) * t_sc_a_r.s;
  assign pround    = pprod_b_r + 64'sd536870912;
  assign qround    = qprod_b_r + 64'sd536870912;
  assign sx_nxt    = SUM_W'(xp1_d_r) - SUM_W'(xp2_d_r) + SUM_W'(64'sd536870912);
  assign sy_nxt    = SUM_W'(yp1_d_r) + SUM_W'(yp2_d_r) + SUM_W'(64'sd536870912);
  assign posx      = POS_W'(offx_e_r) + POS_W'(center_x);
  assign posy      = POS_W'(offy_e_r) + POS_W'(center_y);
  assign clx       = clamp32(posx);
  assign cly       = clamp32(posy);

  // Payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      // A: unfold quadrants
      t_sc_a_r  <= quad_map(slot_i.lt, slot_i.quad_t);
      r_sc_a_r  <= quad_map(slot_i.lr, slot_i.quad_r);
      // B: semi-axis products
      pprod_b_r <= pprod_nxt;
      qprod_b_r <= qprod_nxt;
      r_sc_b_r  <= r_sc_a_r;
      // C: round back to Q16.16
      p_c_r     <= pround[62:30];
      q_c_r     <= qround[62:30];
      r_sc_c_r  <= r_sc_b_r;
      // D: rotation products
      xp1_d_r   <= r_sc_c_r.c * p_c_r;
      xp2_d_r   <= r_sc_c_r.s * q_c_r;
      yp1_d_r   <= r_sc_c_r.s * p_c_r;
      yp2_d_r   <= r_sc_c_r.c * q_c_r;
      // E: sum and round offsets
      offx_e_r  <= sx_nxt[SUM_W-2:30];
      offy_e_r  <= sy_nxt[SUM_W-2:30];
      // F: translate and saturate
      res_r.px  <= clx[31:0];
      res_r.py  <= cly[31:0];
      res_r.ovf <= clx[32] | cly[32];
    end
  end

  assign res_vld = vld_r[5];
  assign res     = res_r;

endmodule

### hw/rtl/ellipse_point_eval.sv
// ----------------------------------------------------------------------------
// ellipse_point_eval - point on a scaled, rotated, translated ellipse
// One parametric angle in, one saturated Q16.16 point out, through a row
// of CORDIC cells and a multiply/rotate/translate pipeline.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | tdata[15:0] param_angle
//  out_    | out | out_tvalid/out_tready| tdata x/y, tuser overflow
//  cfg_    | in  | APB, pready tied high| five registers at 4*index
//
//  One item per cycle while the skid register is empty. Path: NUM_CELLS (16) CORDIC
//  cells, six arithmetic stages and the output register.
//  Both sines/cosines come from the same cell row, one lane each.
//  Reset clears valid bits and loads a = b = 1.0, centre 0, rotation 0.
//  A stalled result parks in a skid register; in_tready drops only while
//  that register is full.
// ----------------------------------------------------------------------------
module ellipse_point_eval (
  input  logic                            clk,
  input  logic                            rst_n,
  // input items
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,   // [15:0] param_angle
  // result items
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [63:0]                     out_tdata,  // [31:0] point_x, [63:32] point_y
  output logic                            out_tuser,  // [0] overflow
  // configuration
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [epe_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);
  import epe_pkg::*;

  logic [30:0]        semi_a_r, semi_b_r;
  logic signed [31:0] center_x_r, center_y_r;
  logic [15:0]        rot_r;
  reg_idx_t           cfg_idx;
  logic               cfg_wr;

  slot_t chain [NUM_CELLS+1];
  logic  en;
  logic  res_vld;
  res_t  res;
  logic  take;

  logic  out_valid_r, skid_valid_r;
  res_t  out_data_r, skid_data_r;

  // Register file
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      semi_a_r   <= 31'd65536;
      semi_b_r   <= 31'd65536;
      center_x_r <= '0;
      center_y_r <= '0;
      rot_r      <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SEMI_A:   semi_a_r   <= cfg_pwdata[30:0];
        REG_SEMI_B:   semi_b_r   <= cfg_pwdata[30:0];
        REG_CENTER_X: center_x_r <= $signed(cfg_pwdata);
        REG_CENTER_Y: center_y_r <= $signed(cfg_pwdata);
        REG_ROTATION: rot_r      <= cfg_pwdata[15:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SEMI_A:   cfg_prdata = {1'b0, semi_a_r};
      REG_SEMI_B:   cfg_prdata = {1'b0, semi_b_r};
      REG_CENTER_X: cfg_prdata = center_x_r;
      REG_CENTER_Y: cfg_prdata = center_y_r;
      REG_ROTATION: cfg_prdata = {16'h0000, rot_r};
      default:      cfg_prdata = '0;
    endcase
  end

  // Pipeline runs unless the skid register holds an item
  assign en        = ~skid_valid_r;
  assign in_tready = en;

  // Seed both lanes at the head of the row
  always_comb begin
    chain[0].vld    = in_tvalid;
    chain[0].quad_t = phase_quad(in_tdata);
    chain[0].quad_r = phase_quad(rot_r);
    chain[0].lt     = lane_seed(in_tdata);
    chain[0].lr     = lane_seed(rot_r);
  end

  // Row of CORDIC cells
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    epe_cordic_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .step   (STEP_W'(g)),
      .slot_i (chain[g]),
      .slot_o (chain[g+1])
    );
  end

  epe_transform u_xform (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .slot_i   (chain[NUM_CELLS]),
    .semi_a   (semi_a_r),
    .semi_b   (semi_b_r),
    .center_x (center_x_r),
    .center_y (center_y_r),
    .res_vld  (res_vld),
    .res      (res)
  );

  // Output register with skid stage
  assign take = en & res_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= take;
      end
    end else if (take) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (take) begin
        out_data_r <= res;
      end
    end else if (take) begin
      skid_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data_r.py, out_data_r.px};
  assign out_tuser  = out_data_r.ovf;

`ifndef SYNTHESIS
  // A parked item implies a valid output item ahead of it
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  // Skid fills only when the output item was stalled
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_tready && res_vld))
    else $error("skid register filled without a stall");

  // Nothing is taken from the pipeline while the skid register is full
  a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !take && !in_tready)
    else $error("pipeline advanced while skid register full");
`endif

endmodule
